>>> rtl/rpt_pkg.sv
// Shared types and constants for the random permutation table.
// Holds table geometry, action codes and the controller/datapath interface structs.
// No dependencies.
package rpt_pkg;

    // Table geometry and field widths
    localparam int TABLE_DEPTH = 1024;
    localparam int ADDR_W      = $clog2(TABLE_DEPTH);
    localparam int VALUE_W     = 10;
    localparam int COUNT_W     = 11;
    localparam int WORD_W      = 31;
    localparam int STEP_W      = $clog2(WORD_W);

    // Configuration port
    localparam int PADDR_W = 3;
    localparam int PDATA_W = 32;
    localparam logic [COUNT_W-1:0] COUNT_RESET = COUNT_W'(TABLE_DEPTH);
    localparam logic REG_COUNT = 1'b0;

    // Item actions
    typedef enum logic [1:0] {
        ACT_BEGIN   = 2'd0,
        ACT_SHUFFLE = 2'd1,
        ACT_NEXT    = 2'd2,
        ACT_LOOKUP  = 2'd3
    } t_action;

    // Table read address source
    typedef enum logic [1:0] {
        ADR_POS,
        ADR_REM,
        ADR_RPOS
    } t_addr_sel;

    // Controller to datapath commands
    typedef struct packed {
        logic      load;
        logic      div_start;
        logic      div_sel_idx;
        logic      rd_en;
        t_addr_sel rd_sel;
        logic      cap_a;
        logic      wr_p;
        logic      wr_j;
        logic      fill_wr;
        logic      begin_set;
        logic      spos_dec;
        logic      rpos_inc;
        logic      respond;
        logic      resp_mem;
        logic      resp_err;
    } t_cmd;

    // Datapath to controller status
    typedef struct packed {
        logic fill_last;
        logic div_done;
        logic spos_zero;
        logic rpos_ok;
    } t_sts;

endpackage

>>> rtl/random_permutation_table.sv
// Random permutation table (Sattolo shuffle) with APB count register.
// Shuffle and lookup run through the 31-step remainder unit, begin through the
// one-entry-per-cycle identity fill. A shuffle when already finished, and a next
// past the end, are answered straight from idle without a table access.
// One item at a time; results carry a one-cycle strobe and cannot be stalled.
// Synchronous reset clears positions and control; count resets to 1024; table is unset.
module random_permutation_table (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic [1:0]                    i_action,
    input  logic [rpt_pkg::WORD_W-1:0]    i_rand_word,
    input  logic [rpt_pkg::WORD_W-1:0]    i_index,
    output logic                          o_valid,
    output logic [rpt_pkg::VALUE_W-1:0]   o_value,
    output logic                          o_shuffle_done,
    output logic                          o_error,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [rpt_pkg::PADDR_W-1:0]   paddr,
    input  logic [rpt_pkg::PDATA_W-1:0]   pwdata,
    output logic [rpt_pkg::PDATA_W-1:0]   prdata,
    output logic                          pready
);

    logic [rpt_pkg::COUNT_W-1:0] r_count;
    logic [rpt_pkg::COUNT_W-1:0] w_n;
    logic                        w_reg_count;
    rpt_pkg::t_cmd               w_cmd;
    rpt_pkg::t_sts               w_sts;

    assign pready      = 1'b1;
    assign w_reg_count = (paddr[2] == rpt_pkg::REG_COUNT);

    // Count register write transfer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= rpt_pkg::COUNT_RESET;
        end else if (psel && penable && pwrite && pready && w_reg_count) begin
            r_count <= pwdata[rpt_pkg::COUNT_W-1:0];
        end
    end

    assign prdata = w_reg_count ? rpt_pkg::PDATA_W'(r_count) : '0;

    // Clamp count to 1..table depth
    always_comb begin
        priority if (r_count == '0) begin
            w_n = rpt_pkg::COUNT_W'(1);
        end else if (r_count > rpt_pkg::COUNT_W'(rpt_pkg::TABLE_DEPTH)) begin
            w_n = rpt_pkg::COUNT_W'(rpt_pkg::TABLE_DEPTH);
        end else begin
            w_n = r_count;
        end
    end

    rpt_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (start),
        .i_action (rpt_pkg::t_action'(i_action)),
        .i_sts    (w_sts),
        .o_cmd    (w_cmd),
        .o_busy   (busy)
    );

    rpt_datapath u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (w_cmd),
        .i_n            (w_n),
        .i_rand_word    (i_rand_word),
        .i_index        (i_index),
        .o_sts          (w_sts),
        .o_valid        (o_valid),
        .o_value        (o_value),
        .o_shuffle_done (o_shuffle_done),
        .o_error        (o_error)
    );

    // An error result carries a zero value
    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_error) |-> (o_value == '0))
        else $error("error result without zero value");

    // An accepted item either occupies the block or answers at once
    a_accept_progress: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> (busy || o_valid))
        else $error("accepted item neither started nor answered");

    // Every return to idle delivers a result
    a_idle_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($fell(busy) && $past(i_rst_n)) |-> o_valid)
        else $error("block went idle without a result");

endmodule

>>> rtl/rpt_div.sv
// Iterative remainder unit: one dividend bit per cycle, restoring form.
// Depends on rpt_pkg for widths.
module rpt_div (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_start,
    input  logic [rpt_pkg::WORD_W-1:0]     i_dividend,
    input  logic [rpt_pkg::COUNT_W-1:0]    i_divisor,
    output logic                           o_done,
    output logic [rpt_pkg::ADDR_W-1:0]     o_rem
);

    logic                          r_busy;
    logic                          r_done;
    logic [rpt_pkg::STEP_W-1:0]    r_step;
    logic [rpt_pkg::WORD_W-1:0]    r_dvd;
    logic [rpt_pkg::COUNT_W-1:0]   r_dsr;
    logic [rpt_pkg::COUNT_W-1:0]   r_rem;

    logic [rpt_pkg::COUNT_W:0]     w_trial;
    logic [rpt_pkg::COUNT_W:0]     w_diff;
    logic                          w_fit;
    logic [rpt_pkg::COUNT_W-1:0]   n_rem;

    // Shift in the next dividend bit and subtract where the divisor fits
    always_comb begin
        w_trial = {r_rem, r_dvd[rpt_pkg::WORD_W-1]};
        w_diff  = w_trial - {1'b0, r_dsr};
        w_fit   = (w_trial >= {1'b0, r_dsr});
        n_rem   = w_fit ? w_diff[rpt_pkg::COUNT_W-1:0] : w_trial[rpt_pkg::COUNT_W-1:0];
    end

    // Sequence the steps
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_step <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_step <= '0;
            end else if (r_busy) begin
                r_step <= r_step + 1'b1;
                if (r_step == rpt_pkg::STEP_W'(rpt_pkg::WORD_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // Operand and partial remainder registers
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_dvd <= i_dividend;
            r_dsr <= i_divisor;
            r_rem <= '0;
        end else if (r_busy) begin
            r_dvd <= {r_dvd[rpt_pkg::WORD_W-2:0], 1'b0};
            r_rem <= n_rem;
        end
    end

    assign o_done = r_done;
    // Remainder is below the divisor, which never exceeds the table depth
    assign o_rem  = r_rem[rpt_pkg::ADDR_W-1:0];

endmodule

>>> rtl/rpt_ctrl.sv
// Controller state machine for the random permutation table.
// Depends on rpt_pkg; drives rpt_datapath through t_cmd and reads t_sts.
module rpt_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  rpt_pkg::t_action  i_action,
    input  rpt_pkg::t_sts     i_sts,
    output rpt_pkg::t_cmd     o_cmd,
    output logic              o_busy
);

    typedef enum logic [3:0] {
        S_IDLE,
        S_FILL,
        S_DIV_GO,
        S_DIV_WAIT,
        S_RD_P,
        S_RD_J,
        S_WR_P,
        S_WR_J,
        S_READ,
        S_RESP
    } t_state;

    t_state           r_state;
    t_state           n_state;
    rpt_pkg::t_action r_act;
    rpt_pkg::t_action n_act;

    // Next state and command decode
    always_comb begin
        n_state = r_state;
        n_act   = r_act;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    o_cmd.load = 1'b1;
                    n_act      = i_action;
                    unique case (i_action)
                        rpt_pkg::ACT_BEGIN: n_state = S_FILL;
                        rpt_pkg::ACT_SHUFFLE: begin
                            if (i_sts.spos_zero) begin
                                o_cmd.respond = 1'b1;
                            end else begin
                                n_state = S_DIV_GO;
                            end
                        end
                        rpt_pkg::ACT_NEXT: begin
                            if (i_sts.rpos_ok) begin
                                n_state = S_READ;
                            end else begin
                                o_cmd.respond  = 1'b1;
                                o_cmd.resp_err = 1'b1;
                            end
                        end
                        rpt_pkg::ACT_LOOKUP: n_state = S_DIV_GO;
                        default: n_state = S_IDLE;
                    endcase
                end
            end
            S_FILL: begin
                o_cmd.fill_wr = 1'b1;
                if (i_sts.fill_last) begin
                    o_cmd.begin_set = 1'b1;
                    o_cmd.respond   = 1'b1;
                    n_state         = S_IDLE;
                end
            end
            S_DIV_GO: begin
                o_cmd.div_start   = 1'b1;
                o_cmd.div_sel_idx = (r_act == rpt_pkg::ACT_LOOKUP);
                n_state           = S_DIV_WAIT;
            end
            S_DIV_WAIT: begin
                if (i_sts.div_done) begin
                    n_state = (r_act == rpt_pkg::ACT_LOOKUP) ? S_READ : S_RD_P;
                end
            end
            S_RD_P: begin
                o_cmd.rd_en  = 1'b1;
                o_cmd.rd_sel = rpt_pkg::ADR_POS;
                n_state      = S_RD_J;
            end
            S_RD_J: begin
                o_cmd.rd_en  = 1'b1;
                o_cmd.rd_sel = rpt_pkg::ADR_REM;
                o_cmd.cap_a  = 1'b1;
                n_state      = S_WR_P;
            end
            S_WR_P: begin
                o_cmd.wr_p = 1'b1;
                n_state    = S_WR_J;
            end
            S_WR_J: begin
                o_cmd.wr_j     = 1'b1;
                o_cmd.spos_dec = 1'b1;
                o_cmd.respond  = 1'b1;
                n_state        = S_IDLE;
            end
            S_READ: begin
                o_cmd.rd_en    = 1'b1;
                o_cmd.rd_sel   = (r_act == rpt_pkg::ACT_NEXT) ? rpt_pkg::ADR_RPOS
                                                               : rpt_pkg::ADR_REM;
                o_cmd.rpos_inc = (r_act == rpt_pkg::ACT_NEXT);
                n_state        = S_RESP;
            end
            S_RESP: begin
                o_cmd.respond  = 1'b1;
                o_cmd.resp_mem = 1'b1;
                n_state        = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Hold state and the action of the item in flight
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_act   <= rpt_pkg::ACT_BEGIN;
        end else begin
            r_state <= n_state;
            r_act   <= n_act;
        end
    end

    assign o_busy = (r_state != S_IDLE);

endmodule

>>> rtl/rpt_datapath.sv
// Datapath: permutation memory, positions, remainder unit and result registers.
// Depends on rpt_pkg and rpt_div; commanded by rpt_ctrl.
module rpt_datapath (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  rpt_pkg::t_cmd                 i_cmd,
    input  logic [rpt_pkg::COUNT_W-1:0]   i_n,
    input  logic [rpt_pkg::WORD_W-1:0]    i_rand_word,
    input  logic [rpt_pkg::WORD_W-1:0]    i_index,
    output rpt_pkg::t_sts                 o_sts,
    output logic                          o_valid,
    output logic [rpt_pkg::VALUE_W-1:0]   o_value,
    output logic                          o_shuffle_done,
    output logic                          o_error
);

    logic [rpt_pkg::VALUE_W-1:0] mem [rpt_pkg::TABLE_DEPTH];

    logic [rpt_pkg::VALUE_W-1:0]  r_rdata;
    logic [rpt_pkg::VALUE_W-1:0]  r_tp;
    logic [rpt_pkg::WORD_W-1:0]   r_rand;
    logic [rpt_pkg::WORD_W-1:0]   r_index;
    logic [rpt_pkg::ADDR_W-1:0]   r_fill;
    logic [rpt_pkg::ADDR_W-1:0]   r_spos;
    logic [rpt_pkg::COUNT_W-1:0]  r_rpos;
    logic                         r_valid;
    logic [rpt_pkg::VALUE_W-1:0]  r_value;
    logic                         r_done;
    logic                         r_err;

    logic [rpt_pkg::ADDR_W-1:0]   n_spos;
    logic [rpt_pkg::COUNT_W-1:0]  w_nm1;
    logic [rpt_pkg::ADDR_W-1:0]   w_rd_addr;
    logic [rpt_pkg::ADDR_W-1:0]   w_wr_addr;
    logic [rpt_pkg::VALUE_W-1:0]  w_wr_data;
    logic                         w_wr_en;
    logic [rpt_pkg::WORD_W-1:0]   w_dividend;
    logic [rpt_pkg::COUNT_W-1:0]  w_divisor;
    logic                         w_div_done;
    logic [rpt_pkg::ADDR_W-1:0]   w_rem;

    assign w_nm1 = i_n - 1'b1;

    // Remainder unit: shuffle uses rand mod position, lookup uses index mod count
    assign w_dividend = i_cmd.div_sel_idx ? r_index : r_rand;
    assign w_divisor  = i_cmd.div_sel_idx ? i_n : {1'b0, r_spos};

    rpt_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_cmd.div_start),
        .i_dividend (w_dividend),
        .i_divisor  (w_divisor),
        .o_done     (w_div_done),
        .o_rem      (w_rem)
    );

    // Select read address
    always_comb begin
        unique case (i_cmd.rd_sel)
            rpt_pkg::ADR_POS:  w_rd_addr = r_spos;
            rpt_pkg::ADR_REM:  w_rd_addr = w_rem;
            rpt_pkg::ADR_RPOS: w_rd_addr = r_rpos[rpt_pkg::ADDR_W-1:0];
            default:           w_rd_addr = r_spos;
        endcase
    end

    // Select the single write: identity fill, or one half of a swap
    always_comb begin
        w_wr_en   = i_cmd.fill_wr | i_cmd.wr_p | i_cmd.wr_j;
        w_wr_addr = r_fill;
        w_wr_data = rpt_pkg::VALUE_W'(r_fill);
        priority if (i_cmd.wr_p) begin
            w_wr_addr = r_spos;
            w_wr_data = r_rdata;
        end else if (i_cmd.wr_j) begin
            w_wr_addr = w_rem;
            w_wr_data = r_tp;
        end else begin
            w_wr_addr = r_fill;
            w_wr_data = rpt_pkg::VALUE_W'(r_fill);
        end
    end

    // Table memory with registered read
    always_ff @(posedge i_clk) begin
        if (w_wr_en) begin
            mem[w_wr_addr] <= w_wr_data;
        end
        if (i_cmd.rd_en) begin
            r_rdata <= mem[w_rd_addr];
        end
    end

    // Next shuffle position
    always_comb begin
        priority if (i_cmd.begin_set) begin
            n_spos = w_nm1[rpt_pkg::ADDR_W-1:0];
        end else if (i_cmd.spos_dec) begin
            n_spos = r_spos - 1'b1;
        end else begin
            n_spos = r_spos;
        end
    end

    // Positions and result strobe
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_spos  <= '0;
            r_rpos  <= '0;
            r_valid <= 1'b0;
        end else begin
            r_spos  <= n_spos;
            r_valid <= i_cmd.respond;
            if (i_cmd.begin_set) begin
                r_rpos <= '0;
            end else if (i_cmd.rpos_inc) begin
                r_rpos <= r_rpos + 1'b1;
            end
        end
    end

    // Operands, fill counter, swap temporary and result payload
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_rand  <= i_rand_word;
            r_index <= i_index;
            r_fill  <= '0;
        end else if (i_cmd.fill_wr) begin
            r_fill <= r_fill + 1'b1;
        end
        if (i_cmd.cap_a) begin
            r_tp <= r_rdata;
        end
        if (i_cmd.respond) begin
            r_value <= i_cmd.resp_mem ? r_rdata : '0;
            r_done  <= (n_spos == '0);
            r_err   <= i_cmd.resp_err;
        end
    end

    // Status back to the controller
    assign o_sts.fill_last = ({1'b0, r_fill} == w_nm1);
    assign o_sts.div_done  = w_div_done;
    assign o_sts.spos_zero = (r_spos == '0);
    assign o_sts.rpos_ok   = (r_rpos < i_n);

    assign o_valid        = r_valid;
    assign o_value        = r_value;
    assign o_shuffle_done = r_done;
    assign o_error        = r_err;

endmodule

>>> tb/tb_random_permutation_table.sv
// Self-checking testbench for random_permutation_table: command-style items, APB count register.
// Predicts each result with an in-bench model of the table, checks every result strobe.
// Depends on rpt_pkg and the random_permutation_table RTL.
`timescale 1ns / 100ps

module tb_random_permutation_table;

    localparam logic [rpt_pkg::PADDR_W-1:0] COUNT_ADDR =
        rpt_pkg::PADDR_W'(4 * rpt_pkg::REG_COUNT);
    localparam int ITEMS_TARGET  = 1200;
    localparam int NO_GAP_FROM   = 1050;
    localparam int STALL_LIMIT   = 4000;
    localparam int SETTLE_CYCLES = 40;
    localparam int MAX_REPORTS   = 10;

    typedef struct {
        logic [rpt_pkg::VALUE_W-1:0] value;
        logic                        done;
        logic                        err;
    } t_perm_result;

    // Block ports
    logic                          i_clk = 1'b0;
    logic                          i_rst_n = 1'b0;
    logic                          start = 1'b0;
    logic                          busy;
    logic [1:0]                    i_action = rpt_pkg::ACT_BEGIN;
    logic [rpt_pkg::WORD_W-1:0]    i_rand_word = '0;
    logic [rpt_pkg::WORD_W-1:0]    i_index = '0;
    logic                          o_valid;
    logic [rpt_pkg::VALUE_W-1:0]   o_value;
    logic                          o_shuffle_done;
    logic                          o_error;
    logic                          psel = 1'b0;
    logic                          penable = 1'b0;
    logic                          pwrite = 1'b0;
    logic [rpt_pkg::PADDR_W-1:0]   paddr = '0;
    logic [rpt_pkg::PDATA_W-1:0]   pwdata = '0;
    logic [rpt_pkg::PDATA_W-1:0]   prdata;
    logic                          pready;

    // Shadow state of the permutation
    logic [rpt_pkg::VALUE_W-1:0]   shadow_table [rpt_pkg::TABLE_DEPTH];
    logic [rpt_pkg::ADDR_W-1:0]    shadow_spos = '0;
    logic [rpt_pkg::COUNT_W-1:0]   shadow_rpos = '0;
    logic [rpt_pkg::COUNT_W-1:0]   shadow_count = rpt_pkg::COUNT_RESET;

    t_perm_result         awaited_results [$];
    int                   items_sent = 0;
    int                   mismatches = 0;
    int                   stall_cycles = 0;
    bit                   gaps_off = 1'b0;

    random_permutation_table i_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .busy           (busy),
        .i_action       (i_action),
        .i_rand_word    (i_rand_word),
        .i_index        (i_index),
        .o_valid        (o_valid),
        .o_value        (o_value),
        .o_shuffle_done (o_shuffle_done),
        .o_error        (o_error),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready)
    );

    always #2 i_clk = ~i_clk;

    // Clamp the programmed count to the usable table size
    function automatic int unsigned live_entries();
        int unsigned n;
        n = shadow_count;
        if (n == 0) n = 1;
        if (n > rpt_pkg::TABLE_DEPTH) n = rpt_pkg::TABLE_DEPTH;
        return n;
    endfunction

    // Advance the shadow permutation by one item and return its result
    function automatic t_perm_result permute_step(rpt_pkg::t_action act,
                                                  logic [rpt_pkg::WORD_W-1:0] rnd,
                                                  logic [rpt_pkg::WORD_W-1:0] idx);
        t_perm_result                res;
        int unsigned                 n;
        int unsigned                 p;
        int unsigned                 j;
        int unsigned                 k;
        logic [rpt_pkg::VALUE_W-1:0] held;
        n = live_entries();
        res = '{value: '0, done: 1'b0, err: 1'b0};
        case (act)
            rpt_pkg::ACT_BEGIN: begin
                for (k = 0; k < n; k++) shadow_table[k] = rpt_pkg::VALUE_W'(k);
                shadow_spos = rpt_pkg::ADDR_W'(n - 1);
                shadow_rpos = '0;
            end
            rpt_pkg::ACT_SHUFFLE: begin
                if (shadow_spos != 0) begin
                    p = shadow_spos;
                    j = rnd % p;
                    held = shadow_table[p];
                    shadow_table[p] = shadow_table[j];
                    shadow_table[j] = held;
                    shadow_spos = shadow_spos - 1'b1;
                end
            end
            rpt_pkg::ACT_NEXT: begin
                if (shadow_rpos < n) begin
                    res.value = shadow_table[shadow_rpos];
                    shadow_rpos = shadow_rpos + 1'b1;
                end else begin
                    res.err = 1'b1;
                end
            end
            default: begin
                res.value = shadow_table[idx % n];
            end
        endcase
        res.done = (shadow_spos == 0);
        return res;
    endfunction

    function automatic logic [rpt_pkg::WORD_W-1:0] rand_word31();
        return rpt_pkg::WORD_W'($urandom);
    endfunction

    task automatic flag_mismatch(string what, int unsigned exp_v, int unsigned act_v);
        mismatches++;
        if (mismatches <= MAX_REPORTS)
            $display("[%0t] MISMATCH %s: expected %0d, got %0d", $time, what, exp_v, act_v);
    endtask

    // Send one item; start stays high after the transfer until the next call or a drain
    task automatic send_item(rpt_pkg::t_action act, logic [rpt_pkg::WORD_W-1:0] rnd,
                             logic [rpt_pkg::WORD_W-1:0] idx);
        int gap;
        if (!gaps_off && $urandom_range(3) == 0) begin
            gap = $urandom_range(9, 1);
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        start       <= 1'b1;
        i_action    <= act;
        i_rand_word <= rnd;
        i_index     <= idx;
        do @(posedge i_clk); while (busy);
        awaited_results.push_back(permute_step(act, rnd, idx));
        items_sent++;
    endtask

    // Drop start and hold until every result is in and the block is idle
    task automatic drain();
        start <= 1'b0;
        while (awaited_results.size() != 0 || busy) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    // One APB transfer, after which psel and penable drop and the bus idles
    task automatic apb_access(logic wr, logic [rpt_pkg::PADDR_W-1:0] addr,
                              logic [rpt_pkg::PDATA_W-1:0] wdata,
                              output logic [rpt_pkg::PDATA_W-1:0] rdata);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= addr;
        pwdata  <= wdata;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        rdata = prdata;
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge i_clk);
    endtask

    // Program the count and read it back; only called with the block drained
    task automatic write_count(logic [rpt_pkg::COUNT_W-1:0] cnt);
        logic [rpt_pkg::PDATA_W-1:0] rd;
        apb_access(1'b1, COUNT_ADDR, rpt_pkg::PDATA_W'(cnt), rd);
        shadow_count = cnt;
        apb_access(1'b0, COUNT_ADDR, '0, rd);
        if (rd[rpt_pkg::COUNT_W-1:0] !== cnt)
            flag_mismatch("count readback", cnt, rd[rpt_pkg::COUNT_W-1:0]);
    endtask

    // Compare each result strobe with the oldest expectation
    always @(posedge i_clk) begin
        t_perm_result exp_r;
        if (i_rst_n && o_valid === 1'b1) begin
            if (awaited_results.size() == 0) begin
                flag_mismatch("unexpected result, value", 0, o_value);
            end else begin
                exp_r = awaited_results.pop_front();
                if (o_value !== exp_r.value) flag_mismatch("value", exp_r.value, o_value);
                if (o_shuffle_done !== exp_r.done)
                    flag_mismatch("shuffle_done", exp_r.done, o_shuffle_done);
                if (o_error !== exp_r.err) flag_mismatch("error", exp_r.err, o_error);
            end
        end
    end

    // Abort when nothing has been transferred for too long
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((start && !busy) || o_valid === 1'b1 || (psel && penable && pready))
                stall_cycles <= 0;
            else
                stall_cycles <= stall_cycles + 1;
            if (stall_cycles >= STALL_LIMIT) begin
                $display("end of test: mismatches");
                $finish;
            end
        end
    end

    // Shuffle before any begin: position is zero, nothing moves
    task automatic test_shuffle_after_reset();
        send_item(rpt_pkg::ACT_SHUFFLE, '1, '1);
    endtask

    // Full-depth identity fill, field extremes, first shuffle steps
    task automatic test_identity_fill();
        send_item(rpt_pkg::ACT_BEGIN, '0, '0);
        send_item(rpt_pkg::ACT_LOOKUP, '0, '0);
        send_item(rpt_pkg::ACT_LOOKUP, '0, '1);
        send_item(rpt_pkg::ACT_NEXT, '1, '0);
        send_item(rpt_pkg::ACT_NEXT, '0, '1);
        send_item(rpt_pkg::ACT_SHUFFLE, '1, '0);
        send_item(rpt_pkg::ACT_SHUFFLE, '0, '1);
        send_item(rpt_pkg::ACT_LOOKUP, '0, rpt_pkg::WORD_W'(rpt_pkg::TABLE_DEPTH - 1));
        drain();
    endtask

    // Count of zero clamps to one entry, oversize count clamps to the full table
    task automatic test_clamped_counts();
        write_count('0);
        send_item(rpt_pkg::ACT_BEGIN, '0, '0);
        send_item(rpt_pkg::ACT_NEXT, '0, '0);
        send_item(rpt_pkg::ACT_NEXT, '0, '0);
        send_item(rpt_pkg::ACT_LOOKUP, '0, '1);
        send_item(rpt_pkg::ACT_SHUFFLE, '1, '0);
        drain();
        write_count('1);
        send_item(rpt_pkg::ACT_LOOKUP, '0, 31'h5555_5555);
        drain();
    endtask

    // Two-entry table: single swap, finished shuffle, read past the end
    task automatic test_small_table();
        write_count(rpt_pkg::COUNT_W'(2));
        send_item(rpt_pkg::ACT_BEGIN, '0, '0);
        send_item(rpt_pkg::ACT_SHUFFLE, 31'h2AAA_AAAA, '0);
        send_item(rpt_pkg::ACT_SHUFFLE, '1, '0);
        send_item(rpt_pkg::ACT_NEXT, '0, '0);
        send_item(rpt_pkg::ACT_NEXT, '0, '0);
        send_item(rpt_pkg::ACT_NEXT, '0, '0);
        send_item(rpt_pkg::ACT_LOOKUP, '0, 31'h2AAA_AAAB);
        drain();
    endtask

    // Raise the count without a new begin: reads use the new size on the old table
    task automatic test_count_change_keeps_table();
        write_count(rpt_pkg::COUNT_W'(5));
        send_item(rpt_pkg::ACT_NEXT, '0, '0);
        send_item(rpt_pkg::ACT_LOOKUP, '0, 31'h0000_0009);
        drain();
    endtask

    // Random sessions: mostly begin, shuffles (full for up to 48 entries), reads; some random noise
    task automatic test_random_sessions();
        logic [rpt_pkg::COUNT_W-1:0] cnt;
        int unsigned                 n;
        int                          shuffles;
        int                          nexts;
        int                          lookups;
        int                          k;
        while (items_sent < ITEMS_TARGET) begin
            gaps_off = (items_sent >= NO_GAP_FROM);
            case ($urandom_range(29))
                0:       cnt = '0;
                1:       cnt = '1;
                2:       cnt = rpt_pkg::COUNT_W'(rpt_pkg::TABLE_DEPTH);
                3:       cnt = rpt_pkg::COUNT_W'(1);
                4:       cnt = rpt_pkg::COUNT_W'($urandom_range(rpt_pkg::TABLE_DEPTH - 1, 49));
                default: cnt = rpt_pkg::COUNT_W'($urandom_range(48, 2));
            endcase
            write_count(cnt);
            n = live_entries();
            if ($urandom_range(5) != 0) begin
                send_item(rpt_pkg::ACT_BEGIN, rand_word31(), rand_word31());
                shuffles = (n > 48) ? 40 : int'(n) - 1 + $urandom_range(2);
                for (k = 0; k < shuffles; k++)
                    send_item(rpt_pkg::ACT_SHUFFLE, rand_word31(), rand_word31());
                nexts   = (n > 48) ? 40 : int'(n) + $urandom_range(2);
                lookups = $urandom_range(8);
                while (nexts + lookups > 0) begin
                    if (lookups > 0 && (nexts == 0 || $urandom_range(2) == 0)) begin
                        send_item(rpt_pkg::ACT_LOOKUP, rand_word31(), rand_word31());
                        lookups--;
                    end else begin
                        send_item(rpt_pkg::ACT_NEXT, rand_word31(), rand_word31());
                        nexts--;
                    end
                end
            end else begin
                for (k = $urandom_range(16, 4); k > 0; k--)
                    send_item(rpt_pkg::t_action'($urandom_range(3)), rand_word31(),
                              rand_word31());
            end
            drain();
        end
    endtask

    initial begin
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_shuffle_after_reset();
        test_identity_fill();
        test_clamped_counts();
        test_small_table();
        test_count_change_keeps_table();
        test_random_sessions();
        drain();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (mismatches == 0 && awaited_results.size() == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule
